// ----- src/dial_countdown_timer_top_defines.svh -----
// assertion macros for the dial countdown timer checker
// no dependencies; included by the checker file
`ifndef DIAL_COUNTDOWN_TIMER_TOP_DEFINES_SVH
`define DIAL_COUNTDOWN_TIMER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DCT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define DCT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/dct_pkg.sv -----
// shared types and constants of the dial countdown timer
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package dct_pkg;

  // timer modes
  typedef enum logic [1:0] {
    MODE_SETTING  = 2'd0,
    MODE_RUNNING  = 2'd1,
    MODE_PAUSED   = 2'd2,
    MODE_FINISHED = 2'd3
  } mode_t;

  // input action codes (code 3 is unused)
  localparam logic [1:0] ACT_TICK    = 2'd0;
  localparam logic [1:0] ACT_ENCODER = 2'd1;
  localparam logic [1:0] ACT_BUTTON  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_LONG_PRESS = 2'd0;
  localparam logic [1:0] CFG_MAX_SET    = 2'd1;
  localparam logic [1:0] CFG_ALARM_GAP  = 2'd2;

  // configuration reset values
  localparam logic [15:0] LONG_PRESS_RST = 16'd700;
  localparam logic [12:0] MAX_SET_RST    = 13'd5999;
  localparam logic [9:0]  ALARM_GAP_RST  = 10'd450;

  // tone commands
  localparam logic [12:0] HZ_CHIRP_LO = 13'd4000;
  localparam logic [12:0] HZ_CHIRP_HI = 13'd4500;
  localparam logic [12:0] HZ_PAUSE    = 13'd5000;
  localparam logic [12:0] HZ_START    = 13'd8000;
  localparam logic [7:0]  MS_CHIRP    = 8'd180;
  localparam logic [7:0]  MS_CLICK    = 8'd30;
  localparam logic [7:0]  MS_DETENT   = 8'd25;

  localparam logic [9:0]  CHIRP_SPACING = 10'd200;
  localparam logic [9:0]  MS_PER_SEC    = 10'd1000;

  // input word
  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] encoder_count;
    logic [15:0]        held_ms;
  } in_item_t;

  // result word
  typedef struct packed {
    logic [1:0]  mode;
    logic [22:0] remaining_ms;
    logic [6:0]  display_minutes;
    logic [5:0]  display_seconds;
    logic [12:0] set_seconds_out;
    logic        tone_start;
    logic [12:0] tone_hz;
    logic [7:0]  tone_ms;
    logic        tone_stop;
    logic        exit_request;
  } out_item_t;

  // configuration register values
  typedef struct packed {
    logic [15:0] long_press_ms;
    logic [12:0] max_set_seconds;
    logic [9:0]  alarm_gap_ms;
  } cfg_t;

  // status after one item, handed from the control stage to the display stages
  typedef struct packed {
    mode_t       mode;
    logic [12:0] set_secs;
    logic [22:0] remaining;
    logic        tone_start;
    logic [12:0] tone_hz;
    logic [7:0]  tone_ms;
    logic        tone_stop;
    logic        exit_request;
  } status_t;

endpackage

// ----- src/dct_core.sv -----
// timer control: mode, set seconds, countdown, encoder tracking and alarm pattern
// depends on dct_pkg; registers the status of each accepted word
`timescale 1ns / 1ps

module dct_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            acc,
  input  logic            adv,
  input  dct_pkg::in_item_t in_item,
  input  dct_pkg::cfg_t   cfg,
  output logic            st_valid,
  output dct_pkg::status_t st
);

  // timer state
  dct_pkg::mode_t mode_r, mode_nxt;
  logic [12:0] set_secs_r, set_secs_nxt;
  logic [22:0] remaining_r, remaining_nxt;
  logic [31:0] last_count_r, last_count_nxt;
  logic [9:0]  alarm_phase_r, alarm_phase_nxt;
  logic        alarm_second_r, alarm_second_nxt;

  // status register
  logic             st_valid_r;
  dct_pkg::status_t st_r, st_nxt;

  // encoder detent arithmetic
  logic [32:0]        delta;
  logic [32:0]        delta_adj;
  logic [32:0]        det;
  logic               det_nz;
  logic [31:0]        new_last;
  logic               det_over;
  logic               det_under;
  logic signed [21:0] det_sat;
  logic [5:0]         step;
  logic signed [21:0] step_prod;
  logic signed [21:0] set_sum;
  logic [12:0]        set_clamped;
  logic [22:0]        rc_dec;

  // detents: delta halved, truncated toward zero
  assign delta     = {in_item.encoder_count[31], in_item.encoder_count}
                   - {last_count_r[31], last_count_r};
  assign delta_adj = delta + {32'd0, delta[32]};
  assign det       = {delta_adj[32], delta_adj[32:1]};
  assign det_nz    = |det;
  assign new_last  = last_count_r + {det[30:0], 1'b0};

  // saturate detents; anything past this range clamps the set value anyway
  assign det_over  = !det[32] && (|det[31:14]);
  assign det_under = det[32] && !(&det[31:14]);
  always_comb begin
    priority if (det_over) begin
      det_sat = 22'sd16383;
    end else if (det_under) begin
      det_sat = -22'sd16384;
    end else begin
      det_sat = {{7{det[14]}}, det[14:0]};
    end
  end

  // step size picked by the current set value
  always_comb begin
    priority if (set_secs_r < 13'd60) begin
      step = 6'd5;
    end else if (set_secs_r < 13'd300) begin
      step = 6'd15;
    end else if (set_secs_r < 13'd1200) begin
      step = 6'd30;
    end else begin
      step = 6'd60;
    end
  end

  assign step_prod = det_sat * $signed({16'd0, step});
  assign set_sum   = $signed({9'd0, set_secs_r}) + step_prod;

  // clamp to 0..max
  always_comb begin
    priority if (set_sum < 22'sd0) begin
      set_clamped = 13'd0;
    end else if (set_sum > $signed({9'd0, cfg.max_set_seconds})) begin
      set_clamped = cfg.max_set_seconds;
    end else begin
      set_clamped = set_sum[12:0];
    end
  end

  assign rc_dec = (remaining_r != 23'd0) ? remaining_r - 23'd1 : 23'd0;

  // next state and tone commands for one word
  always_comb begin
    mode_nxt         = mode_r;
    set_secs_nxt     = set_secs_r;
    remaining_nxt    = remaining_r;
    last_count_nxt   = last_count_r;
    alarm_phase_nxt  = alarm_phase_r;
    alarm_second_nxt = alarm_second_r;
    st_nxt           = '0;

    unique case (in_item.action)
      dct_pkg::ACT_TICK: begin
        if (mode_r == dct_pkg::MODE_RUNNING) begin
          remaining_nxt = rc_dec;
          if (rc_dec == 23'd0) begin
            mode_nxt         = dct_pkg::MODE_FINISHED;
            alarm_phase_nxt  = 10'd0;
            alarm_second_nxt = 1'b0;
          end
        end else if (mode_r == dct_pkg::MODE_FINISHED) begin
          if (alarm_phase_r != 10'd0) begin
            alarm_phase_nxt = alarm_phase_r - 10'd1;
          end
        end
        // alarm chirp due
        if (mode_nxt == dct_pkg::MODE_FINISHED && alarm_phase_nxt == 10'd0) begin
          st_nxt.tone_start = 1'b1;
          st_nxt.tone_ms    = dct_pkg::MS_CHIRP;
          if (!alarm_second_nxt) begin
            st_nxt.tone_hz   = dct_pkg::HZ_CHIRP_LO;
            alarm_phase_nxt  = dct_pkg::CHIRP_SPACING;
            alarm_second_nxt = 1'b1;
          end else begin
            st_nxt.tone_hz   = dct_pkg::HZ_CHIRP_HI;
            alarm_phase_nxt  = cfg.alarm_gap_ms;
            alarm_second_nxt = 1'b0;
          end
        end
      end
      dct_pkg::ACT_ENCODER: begin
        if (det_nz) begin
          last_count_nxt = new_last;
          if (mode_r == dct_pkg::MODE_SETTING) begin
            set_secs_nxt = set_clamped;
          end else if (mode_r == dct_pkg::MODE_PAUSED) begin
            mode_nxt          = dct_pkg::MODE_SETTING;
            st_nxt.tone_start = 1'b1;
            st_nxt.tone_hz    = dct_pkg::HZ_CHIRP_LO;
            st_nxt.tone_ms    = dct_pkg::MS_DETENT;
          end
        end
      end
      dct_pkg::ACT_BUTTON: begin
        if (in_item.held_ms > cfg.long_press_ms) begin
          st_nxt.tone_stop    = 1'b1;
          st_nxt.exit_request = 1'b1;
        end else begin
          unique case (mode_r)
            dct_pkg::MODE_SETTING: begin
              if (set_secs_r != 13'd0) begin
                remaining_nxt     = {10'd0, set_secs_r} * {13'd0, dct_pkg::MS_PER_SEC};
                mode_nxt          = dct_pkg::MODE_RUNNING;
                st_nxt.tone_start = 1'b1;
                st_nxt.tone_hz    = dct_pkg::HZ_START;
                st_nxt.tone_ms    = dct_pkg::MS_CLICK;
              end
            end
            dct_pkg::MODE_RUNNING: begin
              mode_nxt          = dct_pkg::MODE_PAUSED;
              st_nxt.tone_start = 1'b1;
              st_nxt.tone_hz    = dct_pkg::HZ_PAUSE;
              st_nxt.tone_ms    = dct_pkg::MS_CLICK;
            end
            dct_pkg::MODE_PAUSED: begin
              mode_nxt          = dct_pkg::MODE_RUNNING;
              st_nxt.tone_start = 1'b1;
              st_nxt.tone_hz    = dct_pkg::HZ_START;
              st_nxt.tone_ms    = dct_pkg::MS_CLICK;
            end
            dct_pkg::MODE_FINISHED: begin
              mode_nxt         = dct_pkg::MODE_SETTING;
              st_nxt.tone_stop = 1'b1;
            end
            default: begin
              mode_nxt = mode_r;
            end
          endcase
        end
      end
      default: begin
        mode_nxt = mode_r;
      end
    endcase

    st_nxt.mode      = mode_nxt;
    st_nxt.set_secs  = set_secs_nxt;
    st_nxt.remaining = remaining_nxt;
  end

  // state registers, updated on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= dct_pkg::MODE_SETTING;
      set_secs_r     <= 13'd0;
      remaining_r    <= 23'd0;
      last_count_r   <= 32'd0;
      alarm_phase_r  <= 10'd0;
      alarm_second_r <= 1'b0;
    end else if (acc) begin
      mode_r         <= mode_nxt;
      set_secs_r     <= set_secs_nxt;
      remaining_r    <= remaining_nxt;
      last_count_r   <= last_count_nxt;
      alarm_phase_r  <= alarm_phase_nxt;
      alarm_second_r <= alarm_second_nxt;
    end
  end

  // status stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
    end else if (adv) begin
      st_valid_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r <= st_nxt;
    end
  end

  assign st_valid = st_valid_r;
  assign st       = st_r;

endmodule

// ----- src/dct_disp.sv -----
// display stages: remaining ms, ceiled seconds and minutes:seconds split
// depends on dct_pkg; two register stages ending in the result register
`timescale 1ns / 1ps

module dct_disp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              st_valid,
  input  dct_pkg::status_t  st,
  output logic              out_valid,
  output dct_pkg::out_item_t out_item
);

  typedef struct packed {
    dct_pkg::mode_t mode;
    logic [22:0]    rem;
    logic [13:0]    tot;
    logic [12:0]    set_secs;
    logic           tone_start;
    logic [12:0]    tone_hz;
    logic [7:0]     tone_ms;
    logic           tone_stop;
    logic           exit_request;
  } mid_t;

  // ceiled seconds: (x / 8) * ceil(2^28 / 125) >> 28 is exact for x below 2^24
  localparam logic [21:0] RECIP_125 = 22'd2147484;
  // floor(t / 60) for t below 2^14: t * ceil(2^20 / 60) >> 20
  localparam logic [14:0] RECIP_60  = 15'd17477;

  logic        mid_valid_r;
  mid_t        mid_r, mid_nxt;
  logic [23:0] rem_up;
  logic [42:0] div_prod;
  logic [22:0] set_ms;

  logic [28:0] q60_prod;
  logic [8:0]  q60;
  logic [8:0]  min_mod;
  logic [13:0] q60_x60;
  logic [13:0] secs;

  logic               out_valid_r;
  dct_pkg::out_item_t out_r, out_nxt;

  // stage one: remaining ms and ceiled seconds
  assign set_ms   = {10'd0, st.set_secs} * {13'd0, dct_pkg::MS_PER_SEC};
  assign rem_up   = {1'b0, st.remaining} + 24'd999;
  assign div_prod = rem_up[23:3] * RECIP_125;

  always_comb begin
    mid_nxt              = '0;
    mid_nxt.mode         = st.mode;
    mid_nxt.set_secs     = st.set_secs;
    mid_nxt.tone_start   = st.tone_start;
    mid_nxt.tone_hz      = st.tone_hz;
    mid_nxt.tone_ms      = st.tone_ms;
    mid_nxt.tone_stop    = st.tone_stop;
    mid_nxt.exit_request = st.exit_request;
    unique case (st.mode)
      dct_pkg::MODE_SETTING: begin
        mid_nxt.rem = set_ms;
        mid_nxt.tot = {1'b0, st.set_secs};
      end
      dct_pkg::MODE_FINISHED: begin
        mid_nxt.rem = 23'd0;
        mid_nxt.tot = 14'd0;
      end
      default: begin
        mid_nxt.rem = st.remaining;
        mid_nxt.tot = div_prod[41:28];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_valid_r <= 1'b0;
    end else if (adv) begin
      mid_valid_r <= st_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mid_r <= mid_nxt;
    end
  end

  // stage two: minutes modulo 100 and seconds
  assign q60_prod = mid_r.tot * RECIP_60;
  assign q60      = q60_prod[28:20];
  assign q60_x60  = {q60[7:0], 6'd0} - {3'd0, q60, 2'd0};
  assign secs     = mid_r.tot - q60_x60;

  always_comb begin
    priority if (q60 >= 9'd200) begin
      min_mod = q60 - 9'd200;
    end else if (q60 >= 9'd100) begin
      min_mod = q60 - 9'd100;
    end else begin
      min_mod = q60;
    end
  end

  always_comb begin
    out_nxt.mode            = mid_r.mode;
    out_nxt.remaining_ms    = mid_r.rem;
    out_nxt.display_minutes = min_mod[6:0];
    out_nxt.display_seconds = secs[5:0];
    out_nxt.set_seconds_out = mid_r.set_secs;
    out_nxt.tone_start      = mid_r.tone_start;
    out_nxt.tone_hz         = mid_r.tone_hz;
    out_nxt.tone_ms         = mid_r.tone_ms;
    out_nxt.tone_stop       = mid_r.tone_stop;
    out_nxt.exit_request    = mid_r.exit_request;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= mid_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ----- src/dial_countdown_timer_top.sv -----
// dial countdown timer: top level with handshakes and configuration registers
// depends on dct_pkg, dct_core and dct_disp
//
//   channel | direction | handshake         | payload
//   in_     | input     | in_valid/in_stall | in_data   (dct_pkg::in_item_t)
//   out_    | output    | out_valid/out_stall | out_data (dct_pkg::out_item_t)
//   cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// one word accepted per cycle while in_stall is low; its result is registered in the
// status, middle and result registers in turn before it sits on out_data
// the three stages (control, seconds divide, minutes:seconds split) advance
// together; out_stall with a result waiting freezes them and raises in_stall
// synchronous reset clears mode, set seconds, countdown, encoder count and alarm
// and loads the registers with 700 ms, 5999 s and 450 ms; cfg_ready is always high
`timescale 1ns / 1ps

module dial_countdown_timer_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dct_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output dct_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  logic             adv;
  logic             acc;
  dct_pkg::cfg_t    cfg_r;
  logic             st_valid;
  dct_pkg::status_t st;

  // pipeline moves unless a result waits on a stalled output
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;
  assign acc      = in_valid && adv;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_press_ms   <= dct_pkg::LONG_PRESS_RST;
      cfg_r.max_set_seconds <= dct_pkg::MAX_SET_RST;
      cfg_r.alarm_gap_ms    <= dct_pkg::ALARM_GAP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dct_pkg::CFG_LONG_PRESS: cfg_r.long_press_ms   <= cfg_data;
        dct_pkg::CFG_MAX_SET:    cfg_r.max_set_seconds <= cfg_data[12:0];
        dct_pkg::CFG_ALARM_GAP:  cfg_r.alarm_gap_ms    <= cfg_data[9:0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  // control stage
  dct_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .adv      (adv),
    .in_item  (in_data),
    .cfg      (cfg_r),
    .st_valid (st_valid),
    .st       (st)
  );

  // display stages and result register
  dct_disp u_disp (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .st_valid  (st_valid),
    .st        (st),
    .out_valid (out_valid),
    .out_item  (out_data)
  );

endmodule

// ----- src/dct_checker.sv -----
// port-level checks of the dial countdown timer, bound to the top level
// depends on dct_pkg and dial_countdown_timer_top_defines.svh
`timescale 1ns / 1ps
`include "dial_countdown_timer_top_defines.svh"

module dct_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input dct_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input dct_pkg::out_item_t out_data
);

  logic fin;
  logic in_seen;

  assign fin     = out_data.mode == dct_pkg::MODE_FINISHED;
  assign in_seen = in_valid && !in_stall && (in_data.action != dct_pkg::ACT_TICK
                   || in_data.held_ms == in_data.held_ms);

  // a stalled result holds
  `DCT_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

  // input is held off only while a result waits
  `DCT_ASSERT_IMP(a_stall_cause, clk, rst_n, in_seen || in_stall, !in_stall || (out_valid && out_stall), "input stalled without a waiting result")

  // no tone frequency or length without a tone start
  `DCT_ASSERT_IMP(a_tone_quiet, clk, rst_n, out_valid && !out_data.tone_start, out_data.tone_hz == 13'd0 && out_data.tone_ms == 8'd0, "tone fields set without tone start")

  // a finished timer shows zero time
  `DCT_ASSERT_IMP(a_fin_zero, clk, rst_n, out_valid && fin, out_data.remaining_ms == 23'd0 && out_data.display_minutes == 7'd0 && out_data.display_seconds == 6'd0, "finished mode shows time left")

  // exit always comes with a tone stop
  `DCT_ASSERT_IMP(a_exit_stop, clk, rst_n, out_valid && out_data.exit_request, out_data.tone_stop && !out_data.tone_start && out_data.display_seconds < 6'd60, "exit without tone stop")

endmodule

bind dial_countdown_timer_top dct_checker u_dct_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
